[sv/ssnf_pkg.sv]
// Package for the squared-speech notch and low-pass FIR prefilter.
// Holds widths, the MAC control struct, the coefficient ROM and the saturation and tap helpers.
// Has no dependencies; every other file of the block depends on it.
`default_nettype none

package ssnf_pkg;

	localparam int FIR_TAPS    = 48;
	localparam int TAP_W       = $clog2(FIR_TAPS);
	localparam int ROM_TAPS    = 48;
	localparam int ROM_HALF    = 24;
	localparam int HALF_W      = $clog2(ROM_HALF);

	localparam int SAMPLE_W    = 16;
	localparam int SQ_W        = 31;
	localparam int NOTCH_C_W   = 15;
	localparam int OUT_W       = 36;
	localparam int COEF_W      = 16;
	localparam int PROD_W      = OUT_W + COEF_W;
	localparam int ACC_W       = 56;
	localparam int NSUM_W      = 43;
	localparam int ROUND_SHIFT = 15;

	localparam logic [NOTCH_C_W-1:0] NOTCH_C_RESET = NOTCH_C_W'(31130);
	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(16384);

	typedef logic signed [SAMPLE_W-1:0]  sample_t;
	typedef logic signed [OUT_W-1:0]     value_t;
	typedef logic        [NOTCH_C_W-1:0] notch_c_t;
	typedef logic signed [COEF_W-1:0]    coef_t;
	typedef logic signed [PROD_W-1:0]    prod_t;
	typedef logic signed [ACC_W-1:0]     acc_t;
	typedef logic        [TAP_W-1:0]     tap_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic accum;
	} mac_ctrl_t;

	localparam coef_t LP_HALF [ROM_HALF] = '{
		-16'sd35,   -16'sd36,   -16'sd30,   -16'sd14,   16'sd18,    16'sd66,
		16'sd121,   16'sd169,   16'sd183,   16'sd141,   16'sd26,    -16'sd158,
		-16'sd384,  -16'sd596,  -16'sd723,  -16'sd686,  -16'sd420,  16'sd106,
		16'sd874,   16'sd1819,  16'sd2828,  16'sd3762,  16'sd4481,  16'sd4872
	};

	function automatic coef_t lp_coef(input tap_t j);
		int k;
		logic [HALF_W-1:0] idx;
		k = int'(j);
		if (k >= ROM_TAPS) begin
			return '0;
		end
		if (k >= ROM_HALF) begin
			k = ROM_TAPS - 1 - k;
		end
		idx = HALF_W'(k);
		return LP_HALF[idx];
	endfunction

	function automatic tap_t tap_inc(input tap_t p);
		return (p == TAP_W'(FIR_TAPS - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic value_t sat_out(input acc_t v);
		logic [ACC_W-OUT_W:0] hi;
		hi = v[ACC_W-1:OUT_W-1];
		if (&hi || ~|hi) begin
			return v[OUT_W-1:0];
		end
		return v[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
	endfunction

endpackage

`default_nettype wire

[sv/ssnf_if.sv]
// Valid/ready channel interfaces for speech samples and filtered results.
// Depends on ssnf_pkg for the payload types.
`default_nettype none

interface ssnf_sample_if;
	logic                 valid;
	logic                 ready;
	ssnf_pkg::sample_t    speech_sample;

	modport source (output valid, output speech_sample, input ready);
	modport sink   (input valid, input speech_sample, output ready);
endinterface

interface ssnf_result_if;
	logic                 valid;
	logic                 ready;
	ssnf_pkg::value_t     filtered_value;

	modport source (output valid, output filtered_value, input ready);
	modport sink   (input valid, input filtered_value, output ready);
endinterface

`default_nettype wire

[sv/squared_speech_notch_fir_prefilter_unit.sv]
// Squared-speech DC notch and low-pass FIR prefilter, top level with sequencer.
// Depends on ssnf_pkg, the channel interfaces, ssnf_mac and ssnf_delay_ram.
//
// Each speech sample arrives as one transaction on the speech channel and
// gives exactly one transaction on the filtered channel. The sample is
// squared, passed through the DC notch and then through the 48-tap low-pass
// FIR. All multiplications and accumulations go through one shared MAC unit.
// From acceptance, the sample passes through the square and notch states
// (ST_SQ, ST_NOTCH, ST_NWAIT, ST_NSUM), the FIR state that steps through
// every tap, and the drain state for the memory read and the product
// register, before its result is loaded into the output register. The
// block accepts one sample at a time; speech.ready is high only while the
// sequencer is idle.
// The result register lets the next sample be accepted while the previous
// result still waits; if the receiver stalls that long, the sequencer holds
// the new result until the register frees up.
// Reset clears the notch state, the delay line valid bits and the notch
// coefficient to its default. The coefficient is written through cfg_we and
// cfg_data; the user must write it while no sample is in flight, the block does not enforce this.

`default_nettype none

module squared_speech_notch_fir_prefilter_unit (
	input  wire                      clk,
	input  wire                      arst_n,
	ssnf_sample_if.sink              speech,
	ssnf_result_if.source            filtered,
	input  wire                      cfg_we,
	input  ssnf_pkg::notch_c_t       cfg_data
);
	import ssnf_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SQ    = 3'd1;
	localparam logic [2:0] ST_NOTCH = 3'd2;
	localparam logic [2:0] ST_NWAIT = 3'd3;
	localparam logic [2:0] ST_NSUM  = 3'd4;
	localparam logic [2:0] ST_FIR   = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0]          state_q;
	sample_t             samp_q;
	logic [SQ_W-1:0]     sq_q;
	logic [SQ_W-1:0]     xprev_q;
	value_t              yprev_q;
	notch_c_t            coef_q;
	tap_t                wptr_q;
	tap_t                rd_q;
	tap_t                cnt_q;
	logic [FIR_TAPS-1:0] vld_q;
	logic                issue_s1;
	tap_t                tap_s1;
	logic                hit_s1;
	logic                out_valid_q;
	value_t              out_data_q;

	mac_ctrl_t           mac_ctrl;
	value_t              mac_a;
	coef_t               mac_b;
	prod_t               mac_prod;
	acc_t                mac_acc;
	value_t              ram_rdata;
	logic signed [NSUM_W-1:0] notch_sum;
	value_t              notch_val;
	value_t              fir_val;
	logic                out_free;

	ssnf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.op_a   (mac_a),
		.op_b   (mac_b),
		.prod   (mac_prod),
		.acc    (mac_acc)
	);

	ssnf_delay_ram u_ram (
		.clk   (clk),
		.we    (state_q == ST_NSUM),
		.waddr (wptr_q),
		.wdata (notch_val),
		.raddr (rd_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		mac_ctrl = '0;
		mac_a    = '0;
		mac_b    = '0;
		case (state_q)
			ST_SQ: begin
				mac_ctrl.mul  = 1'b1;
				mac_ctrl.load = 1'b1;
				mac_a         = OUT_W'(samp_q);
				mac_b         = samp_q;
			end
			ST_NOTCH: begin
				mac_ctrl.mul   = 1'b1;
				mac_ctrl.accum = 1'b1;
				mac_a          = yprev_q;
				mac_b          = signed'({1'b0, coef_q});
			end
			ST_NSUM: begin
				mac_ctrl.load = 1'b1;
			end
			default: begin
			end
		endcase
		if (issue_s1) begin
			mac_ctrl.mul   = 1'b1;
			mac_ctrl.accum = 1'b1;
			mac_a          = hit_s1 ? ram_rdata : '0;
			mac_b          = lp_coef(tap_s1);
		end
	end

	assign notch_sum = NSUM_W'(mac_acc >>> ROUND_SHIFT)
		+ NSUM_W'(signed'({1'b0, sq_q})) - NSUM_W'(signed'({1'b0, xprev_q}));
	assign notch_val = sat_out(ACC_W'(notch_sum));
	assign fir_val   = sat_out(mac_acc >>> ROUND_SHIFT);
	assign out_free  = !out_valid_q || filtered.ready;

	assign speech.ready            = (state_q == ST_IDLE);
	assign filtered.valid          = out_valid_q;
	assign filtered.filtered_value = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			xprev_q     <= '0;
			yprev_q     <= '0;
			coef_q      <= NOTCH_C_RESET;
			wptr_q      <= '0;
			rd_q        <= '0;
			cnt_q       <= '0;
			vld_q       <= '0;
			issue_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				coef_q <= cfg_data;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (filtered.valid && filtered.ready) begin
				out_valid_q <= 1'b0;
			end
			issue_s1 <= (state_q == ST_FIR);
			case (state_q)
				ST_IDLE: begin
					if (speech.valid) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					state_q <= ST_NOTCH;
				end
				ST_NOTCH: begin
					state_q <= ST_NWAIT;
				end
				ST_NWAIT: begin
					state_q <= ST_NSUM;
				end
				ST_NSUM: begin
					yprev_q       <= notch_val;
					xprev_q       <= sq_q;
					vld_q[wptr_q] <= 1'b1;
					wptr_q        <= tap_inc(wptr_q);
					rd_q          <= tap_inc(wptr_q);
					cnt_q         <= '0;
					state_q       <= ST_FIR;
				end
				ST_FIR: begin
					rd_q <= tap_inc(rd_q);
					if (cnt_q == TAP_W'(FIR_TAPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (cnt_q == TAP_W'(1)) begin
						cnt_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (speech.valid && speech.ready) begin
			samp_q <= speech.speech_sample;
		end
		if (state_q == ST_NOTCH) begin
			sq_q <= mac_prod[SQ_W-1:0];
		end
		tap_s1 <= cnt_q;
		hit_s1 <= vld_q[rd_q];
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= fir_val;
		end
	end
endmodule

`default_nettype wire

[sv/ssnf_mac.sv]
// Shared multiply-accumulate unit with a registered product stage.
// Depends on ssnf_pkg for widths and the control struct.
`default_nettype none

module ssnf_mac (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ssnf_pkg::mac_ctrl_t  ctrl,
	input  ssnf_pkg::value_t     op_a,
	input  ssnf_pkg::coef_t      op_b,
	output ssnf_pkg::prod_t      prod,
	output ssnf_pkg::acc_t       acc
);
	import ssnf_pkg::*;

	prod_t prod_s1;
	logic  acc_en_s1;
	acc_t  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= ctrl.mul & ctrl.accum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_s1 <= PROD_W'(op_a) * PROD_W'(op_b);
		end
		if (ctrl.load) begin
			acc_q <= ROUND_BIAS;
		end else if (acc_en_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	assign prod = prod_s1;
	assign acc  = acc_q;
endmodule

`default_nettype wire

[sv/ssnf_delay_ram.sv]
// Delay line memory for the FIR: one write port and one registered read port.
// Depends on ssnf_pkg for depth and data width.
`default_nettype none

module ssnf_delay_ram (
	input  wire                clk,
	input  wire                we,
	input  ssnf_pkg::tap_t     waddr,
	input  ssnf_pkg::value_t   wdata,
	input  ssnf_pkg::tap_t     raddr,
	output ssnf_pkg::value_t   rdata
);
	import ssnf_pkg::*;

	value_t mem [FIR_TAPS];
	value_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire
